[rtl/core/pfl_pkg.sv]
// Package: sizes, codes and item types of the page free-list allocator.
`default_nettype none
package pfl_pkg;

  localparam int PAGES   = 4096;
  localparam int PAGE_AW = $clog2(PAGES);
  localparam int IDX_W   = 12;
  localparam int LINK_W  = PAGE_AW + 1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_MARK  = 2'd2,
    ACT_QUERY = 2'd3
  } pfl_action_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_BAD_FREE = 2'd2
  } pfl_status_e;

  localparam logic [1:0] PST_FREE = 2'd1;
  localparam logic [1:0] PST_USED = 2'd2;
  localparam logic [1:0] PST_SLAB = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } pfl_state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] page_index;
  } pfl_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] page_out;
    logic [1:0]       status;
    logic             is_slab;
  } pfl_out_t;

  typedef struct packed {
    pfl_action_e        action;
    logic [PAGE_AW-1:0] page;
    logic               in_range;
  } pfl_op_t;

endpackage
`default_nettype wire

[rtl/core/pfl_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/pfl_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module pfl_front
  import pfl_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire pfl_in_t in_item_i,
  input  wire logic    busy_i,
  output logic         op_valid_o,
  output pfl_op_t      op_o,
  input  wire logic    op_pop_i
);

  pfl_op_t    fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  pfl_op_t    op_in;

  assign in_stall_o = (count_q == 2'd2) || busy_i;
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    op_in.action   = pfl_action_e'(in_item_i.action);
    op_in.page     = PAGE_AW'(in_item_i.page_index);
    op_in.in_range = 32'(in_item_i.page_index) < 32'(PAGES);
  end

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = op_pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, op_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= op_in;
    end
  end

  assign op_valid_o = count_q != 2'd0;
  assign op_o       = fifo_q[rd_ptr_q];

endmodule
`default_nettype wire

[rtl/core/pfl_back.sv]
// Back end: free-list head, link and state memories, sequencer and result register.
`default_nettype none
module pfl_back
  import pfl_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    op_valid_i,
  input  wire pfl_op_t op_i,
  output logic         op_pop_o,
  output logic         busy_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output pfl_out_t     out_item_o
);

  pfl_state_e         state_q, state_d;
  logic [PAGE_AW-1:0] clr_q, clr_d;
  logic [PAGE_AW-1:0] head_q, head_d;
  logic               hv_q, hv_d;
  pfl_op_t            cur_q, cur_d;
  logic               out_valid_q, out_valid_d;
  pfl_out_t           out_q, out_d;
  logic               out_load;

  logic               link_we, st_we, rd_en;
  logic [PAGE_AW-1:0] link_waddr, st_waddr, rd_addr;
  logic [LINK_W-1:0]  link_wdata, link_rdata;
  logic [1:0]         st_wdata, st_rdata;

  pfl_ram #(.WIDTH(LINK_W), .DEPTH(PAGES)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(link_rdata)
  );

  pfl_ram #(.WIDTH(2), .DEPTH(PAGES)) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(st_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    head_d      = head_q;
    hv_d        = hv_q;
    cur_d       = cur_q;
    out_d       = '0;
    out_load    = 1'b0;
    op_pop_o    = 1'b0;
    link_we     = 1'b0;
    link_waddr  = clr_q;
    link_wdata  = {clr_q != '0, clr_q - PAGE_AW'(1)};
    st_we       = 1'b0;
    st_waddr    = clr_q;
    st_wdata    = PST_FREE;
    rd_en       = 1'b0;
    rd_addr     = op_i.page;
    unique case (state_q)
      ST_CLEAR: begin
        link_we = 1'b1;
        st_we   = 1'b1;
        clr_d   = clr_q + PAGE_AW'(1);
        if (clr_q == PAGE_AW'(PAGES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          rd_en    = 1'b1;
          cur_d    = op_i;
          rd_addr  = (op_i.action == ACT_ALLOC) ? head_q : op_i.page;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          unique case (cur_q.action)
            ACT_ALLOC: begin
              if (!hv_q) begin
                out_d.status = STS_EMPTY;
              end else begin
                out_d.page_out = IDX_W'(head_q);
                head_d         = link_rdata[PAGE_AW-1:0];
                hv_d           = link_rdata[PAGE_AW];
                st_we          = 1'b1;
                st_waddr       = head_q;
                st_wdata       = PST_USED;
              end
            end
            ACT_FREE: begin
              if (!cur_q.in_range || !(st_rdata == PST_USED || st_rdata == PST_SLAB)) begin
                out_d.status = STS_BAD_FREE;
              end else begin
                st_we      = 1'b1;
                st_waddr   = cur_q.page;
                st_wdata   = PST_FREE;
                link_we    = 1'b1;
                link_waddr = cur_q.page;
                link_wdata = {hv_q, head_q};
                head_d     = cur_q.page;
                hv_d       = 1'b1;
              end
            end
            ACT_MARK: begin
              if (cur_q.in_range) begin
                st_we    = 1'b1;
                st_waddr = cur_q.page;
                st_wdata = PST_SLAB;
              end
            end
            ACT_QUERY: begin
              out_d.is_slab = cur_q.in_range && (st_rdata == PST_SLAB);
            end
            default: ;
          endcase
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      head_q      <= PAGE_AW'(PAGES - 1);
      hv_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      hv_q        <= hv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign busy_o      = state_q == ST_CLEAR;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

[rtl/core/page_free_list_allocator.sv]
// Top level: page allocator with a LIFO free list.
//
// Input channel in_valid_i / in_stall_o carries an item {action, page_index}:
// allocate, free, mark slab or query slab. Output channel out_valid_o /
// out_stall_i returns one item {page_out, status, is_slab} per input item,
// in order. A transfer completes on a clock edge with valid high, stall low.
// A two-entry queue sits between the front end and the sequencer, and a
// result register sits at the output, so input keeps flowing while a
// result waits.
// The sequencer reads the link and state memories for an item in ST_IDLE,
// then commits the update and loads the result register in ST_EXEC. An
// accepted item passes the queue, ST_IDLE and ST_EXEC before out_valid_o.
// The sequencer takes no new item before the last one commits, owing to the
// read-then-commit loop on the single head register and its link memory read.
// After reset a clearing pass writes every link and state entry, one per
// cycle, over all PAGES (4096) entries; in_stall_o stays high meanwhile.
// While out_stall_i holds a result, the sequencer waits with its read data
// and the queue fills; in_stall_o rises once both queue entries are taken.
`default_nettype none
module page_free_list_allocator
  import pfl_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire pfl_in_t in_item_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output pfl_out_t     out_item_o
);

  logic    busy;
  logic    op_valid;
  logic    op_pop;
  pfl_op_t op;

  pfl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .busy_i    (busy),
    .op_valid_o(op_valid),
    .op_o      (op),
    .op_pop_i  (op_pop)
  );

  pfl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  a_stall_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("item accepted during clearing pass");

  a_accept_fills_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> op_valid)
    else $error("accepted item missing from queue");

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !op_pop)
    else $error("queue popped during clearing pass");

  a_empty_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == STS_EMPTY) |-> out_item_o.page_out == '0)
    else $error("empty allocate returned a page");

endmodule
`default_nettype wire

[dv/pfl_tb_pkg.sv]
// Scoreboard class: free-list shadow state and expected result items for the allocator bench.
package pfl_tb_pkg;
  import pfl_pkg::*;

  class page_ledger;
    logic [PAGE_AW-1:0] head;
    bit                 head_ok;
    logic [PAGE_AW-1:0] link [PAGES];
    bit                 link_ok [PAGES];
    logic [1:0]         pstate [PAGES];
    bit                 held [PAGES];
    logic [PAGE_AW-1:0] held_q [$];
    pfl_out_t           awaited_q [$];
    int                 errors;
    int                 checked;
    int                 taken;
    int                 allocs;
    int                 empties;
    int                 bad_frees;
    int                 slab_hits;

    function new();
      head    = PAGE_AW'(PAGES - 1);
      head_ok = 1'b1;
      for (int i = 0; i < PAGES; i++) begin
        link[i]    = PAGE_AW'(i - 1);
        link_ok[i] = (i > 0);
        pstate[i]  = PST_FREE;
        held[i]    = 1'b0;
      end
    endfunction

    function void hold_page(logic [PAGE_AW-1:0] pg);
      if (!held[pg]) begin
        held[pg] = 1'b1;
        held_q.push_back(pg);
      end
    endfunction

    function void drop_page(logic [PAGE_AW-1:0] pg);
      if (held[pg]) begin
        held[pg] = 1'b0;
        for (int k = 0; k < held_q.size(); k++) begin
          if (held_q[k] == pg) begin
            held_q.delete(k);
            break;
          end
        end
      end
    endfunction

    function void note_request(pfl_in_t it);
      pfl_out_t           r;
      logic [PAGE_AW-1:0] pg;
      bit                 in_rng;
      r      = '0;
      in_rng = int'(it.page_index) < PAGES;
      pg     = it.page_index[PAGE_AW-1:0];
      taken++;
      case (it.action)
        ACT_ALLOC: begin
          if (!head_ok) begin
            r.status = STS_EMPTY;
            empties++;
          end else begin
            pg         = head;
            r.page_out = IDX_W'(pg);
            head       = link[pg];
            head_ok    = link_ok[pg];
            pstate[pg] = PST_USED;
            hold_page(pg);
            allocs++;
          end
        end
        ACT_FREE: begin
          if (!in_rng || (pstate[pg] != PST_USED && pstate[pg] != PST_SLAB)) begin
            r.status = STS_BAD_FREE;
            bad_frees++;
          end else begin
            pstate[pg]  = PST_FREE;
            link[pg]    = head;
            link_ok[pg] = head_ok;
            head        = pg;
            head_ok     = 1'b1;
            drop_page(pg);
          end
        end
        ACT_MARK: begin
          if (in_rng) pstate[pg] = PST_SLAB;
        end
        default: begin
          r.is_slab = in_rng && (pstate[pg] == PST_SLAB);
          if (r.is_slab) slab_hits++;
        end
      endcase
      awaited_q.push_back(r);
    endfunction

    function void check_reply(pfl_out_t got);
      pfl_out_t want;
      if (awaited_q.size() == 0) begin
        $error("unexpected result item page_out=%0d status=%0d is_slab=%0d",
               got.page_out, got.status, got.is_slab);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      checked++;
      if (got.page_out !== want.page_out) begin
        $error("page_out expected %0d actual %0d", want.page_out, got.page_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.is_slab !== want.is_slab) begin
        $error("is_slab expected %0d actual %0d", want.is_slab, got.is_slab);
        errors++;
      end
    endfunction
  endclass

endpackage

[dv/page_free_list_allocator_tb.sv]
// Testbench top: drives allocate/free/mark/query items and checks every result item.
module page_free_list_allocator_tb
  import pfl_pkg::*;
  import pfl_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {TR_GROW, TR_SHRINK, TR_WILD} traffic_e;

  logic     clk_i        = 1'b0;
  logic     rst_ni       = 1'b0;
  logic     in_valid     = 1'b0;
  logic     in_stall;
  pfl_in_t  in_item      = '0;
  logic     out_valid;
  logic     out_stall    = 1'b0;
  pfl_out_t out_item;
  bit       quiet        = 1'b0;
  bit       hold_off_req = 1'b0;

  page_ledger sb;

  page_free_list_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic pfl_in_t mk(pfl_action_e a, logic [IDX_W-1:0] p);
    pfl_in_t it;
    it.action     = a;
    it.page_index = p;
    return it;
  endfunction

  function automatic pfl_in_t make_item(traffic_e mode);
    pfl_in_t          it;
    int               r;
    int               t_alloc, t_fh, t_fa, t_mh, t_ma;
    logic [IDX_W-1:0] any;
    logic [IDX_W-1:0] mine;
    r    = $urandom_range(0, 99);
    any  = IDX_W'($urandom);
    mine = (sb.held_q.size() != 0) ? sb.held_q[$urandom_range(0, sb.held_q.size() - 1)] : any;
    case (mode)
      TR_GROW: begin
        t_alloc = 50; t_fh = 70; t_fa = 75; t_mh = 85; t_ma = 90;
      end
      TR_SHRINK: begin
        t_alloc = 15; t_fh = 65; t_fa = 70; t_mh = 80; t_ma = 85;
      end
      default: begin
        t_alloc = 30; t_fh = 45; t_fa = 60; t_mh = 70; t_ma = 85;
      end
    endcase
    it = mk(ACT_QUERY, r[0] ? mine : any);
    if (r < t_alloc) begin
      it = mk(ACT_ALLOC, any);
    end else if (r < t_fh) begin
      it = mk(ACT_FREE, mine);
    end else if (r < t_fa) begin
      // keep the list loop-free until the wild phase
      if (mode == TR_WILD || sb.pstate[any] != PST_SLAB || sb.held[any]) it = mk(ACT_FREE, any);
    end else if (r < t_mh) begin
      it = mk(ACT_MARK, mine);
    end else if (r < t_ma) begin
      if (mode == TR_WILD) begin
        if (sb.pstate[any] == PST_FREE) sb.hold_page(any);
        it = mk(ACT_MARK, any);
      end else if (sb.pstate[any] != PST_FREE) begin
        it = mk(ACT_MARK, any);
      end
    end
    return it;
  endfunction

  task automatic send_item(pfl_in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_request(it);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_reply(out_item);
  end

  initial begin
    wait (rst_ni);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int                 guard;
    logic [PAGE_AW-1:0] p;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(mk(ACT_ALLOC, 12'h000));
    send_item(mk(ACT_ALLOC, 12'hFFF));
    send_item(mk(ACT_QUERY, 12'hFFF));
    send_item(mk(ACT_MARK,  12'hFFF));
    send_item(mk(ACT_QUERY, 12'hFFF));
    send_item(mk(ACT_FREE,  12'hFFF));
    send_item(mk(ACT_FREE,  12'hFFF));
    send_item(mk(ACT_FREE,  12'h000));
    send_item(mk(ACT_MARK,  12'h000));
    send_item(mk(ACT_QUERY, 12'h000));
    send_item(mk(ACT_QUERY, 12'hFFE));
    send_item(mk(ACT_FREE,  12'hFFE));
    send_item(mk(ACT_ALLOC, 12'h555));
    send_item(mk(ACT_ALLOC, 12'hAAA));
    send_item(mk(ACT_MARK,  12'hAAA));
    send_item(mk(ACT_QUERY, 12'h555));
    send_item(mk(ACT_QUERY, 12'hAAA));
    send_item(mk(ACT_FREE,  12'h555));
    send_item(mk(ACT_MARK,  12'hFFE));
    send_item(mk(ACT_FREE,  12'hFFE));

    for (int n = 0; n < 550; n++) begin
      if (n == 50) hold_off_req = 1'b1;
      send_item(make_item(TR_GROW));
    end

    repeat (3) send_item(mk(ACT_ALLOC, IDX_W'($urandom)));
    send_item(mk(ACT_QUERY, IDX_W'($urandom)));
    send_item(mk(ACT_MARK, IDX_W'($urandom)));
    send_item(mk(ACT_ALLOC, IDX_W'($urandom)));

    for (int n = 0; n < 550; n++) send_item(make_item(TR_SHRINK));

    // push a page that is still linked, closing the list into a loop
    if (sb.head_ok) begin
      p = sb.link[sb.head];
      send_item(mk(ACT_MARK, IDX_W'(p)));
      send_item(mk(ACT_FREE, IDX_W'(p)));
    end

    for (int n = 0; n < 650; n++) send_item(make_item(TR_WILD));
    quiet = 1'b1;
    for (int n = 0; n < 130; n++) send_item(make_item(TR_WILD));
    in_valid <= 1'b0;

    guard = 0;
    while (sb.awaited_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.awaited_q.size() != 0) begin
      $error("%0d result items never arrived", sb.awaited_q.size());
      sb.errors++;
    end
    $display("run: %0d items sent, %0d allocations, %0d empty-list replies, %0d rejected frees",
             sb.taken, sb.allocs, sb.empties, sb.bad_frees);
    $display("run: %0d slab query hits, %0d results checked, %0d mismatches",
             sb.slab_hits, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
